// ===== src/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants for the scanline unfilter block.
// ----------------------------------------------------------------------------
package psu_pkg;

    localparam int FT_W    = 3;
    localparam int BYTE_W  = 8;
    localparam int BPP_W   = 4;
    localparam int LEN_W   = 13;
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;

    // Filter type codes
    localparam logic [FT_W-1:0] FT_NONE  = 3'd0;
    localparam logic [FT_W-1:0] FT_SUB   = 3'd1;
    localparam logic [FT_W-1:0] FT_UP    = 3'd2;
    localparam logic [FT_W-1:0] FT_AVG   = 3'd3;
    localparam logic [FT_W-1:0] FT_PAETH = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BPP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN = 1'd1;

    localparam logic [BPP_W-1:0] BPP_RESET = 4'd1;
    localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

    typedef struct packed {
        logic [FT_W-1:0]   filter_type;
        logic [BYTE_W-1:0] filtered_byte;
        logic              first_row;
    } psu_in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] raw_byte;
        logic              end_of_line;
    } psu_out_item_t;

    // Item held in the reconstruct stage while the line store read completes
    typedef struct packed {
        logic [FT_W-1:0]   filter_type;
        logic [BYTE_W-1:0] filtered_byte;
        logic              first_row;
        logic              has_left;
        logic              end_of_line;
    } psu_stage_t;

endpackage

// ===== src/psu_stream_if.sv =====
// ----------------------------------------------------------------------------
// psu_stream_if
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface psu_stream_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ===== src/psu_line_ram.sv =====
// ----------------------------------------------------------------------------
// psu_line_ram
// Line store: one write port, one registered read port. A read of the entry
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module psu_line_ram
    import psu_pkg::*;
#(
    parameter int DEPTH = 4096,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            // write-through bypass for back-to-back items on the same column
            rdata_reg <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/psu_history.sv =====
// ----------------------------------------------------------------------------
// psu_history
// Shift lines of the last reconstructed bytes and the last above bytes,
// tapped one pixel back for the left and upper-left terms.
// ----------------------------------------------------------------------------
module psu_history
    import psu_pkg::*;
#(
    parameter int DEPTH = 8,
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic [BYTE_W-1:0] raw_in,
    input  logic [BYTE_W-1:0] above_in,
    input  logic [IW-1:0]     tap,
    input  logic              has_left,
    input  logic              first_row,
    output logic [BYTE_W-1:0] left,
    output logic [BYTE_W-1:0] upper_left
);

    logic [BYTE_W-1:0] left_reg [DEPTH];
    logic [BYTE_W-1:0] ul_reg   [DEPTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                left_reg[i] <= '0;
                ul_reg[i]   <= '0;
            end
        end
        else if (shift)
        begin
            left_reg[0] <= raw_in;
            ul_reg[0]   <= above_in;
            for (int i = 1; i < DEPTH; i++)
            begin
                left_reg[i] <= left_reg[i-1];
                ul_reg[i]   <= ul_reg[i-1];
            end
        end
    end

    assign left       = has_left ? left_reg[tap] : '0;
    assign upper_left = (has_left && !first_row) ? ul_reg[tap] : '0;

endmodule

// ===== src/psu_predict.sv =====
// ----------------------------------------------------------------------------
// psu_predict
// Filter predictor and reconstruction add for one byte.
// ----------------------------------------------------------------------------
module psu_predict
    import psu_pkg::*;
(
    input  psu_stage_t        stage,
    input  logic [BYTE_W-1:0] left,
    input  logic [BYTE_W-1:0] above,
    input  logic [BYTE_W-1:0] upper_left,
    output logic [BYTE_W-1:0] raw
);

    logic [BYTE_W:0]   avg_sum;
    logic [BYTE_W-1:0] pa;
    logic [BYTE_W-1:0] pb;
    logic [BYTE_W+1:0] ab_sum;
    logic [BYTE_W+1:0] c_dbl;
    logic [BYTE_W+1:0] pc;
    logic [BYTE_W-1:0] paeth;
    logic [BYTE_W-1:0] pred;

    // Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|
    always_comb
    begin
        pa     = (above > upper_left) ? above - upper_left : upper_left - above;
        pb     = (left > upper_left) ? left - upper_left : upper_left - left;
        ab_sum = {2'b00, left} + {2'b00, above};
        c_dbl  = {1'b0, upper_left, 1'b0};
        pc     = (ab_sum > c_dbl) ? ab_sum - c_dbl : c_dbl - ab_sum;

        if (({2'b00, pa} <= {2'b00, pb}) && ({2'b00, pa} <= pc))
        begin
            paeth = left;
        end
        else if ({2'b00, pb} <= pc)
        begin
            paeth = above;
        end
        else
        begin
            paeth = upper_left;
        end
    end

    always_comb
    begin
        avg_sum = {1'b0, left} + {1'b0, above};
        case (stage.filter_type)
            FT_SUB:   pred = left;
            FT_UP:    pred = above;
            FT_AVG:   pred = avg_sum[BYTE_W:1];
            FT_PAETH: pred = paeth;
            default:  pred = '0;
        endcase
        raw = stage.filtered_byte + pred;
    end

endmodule

// ===== src/png_scanline_unfilter.sv =====
// Registers: reconstruct stage, then output. Throughput: 1 item per cycle
// unless the output stalls; the line store has one read and one write port
// and a read of the column written in the same cycle is bypassed. Output
// register plus the reconstruct stage let input flow while a result waits.
// Reset loads config defaults and clears column counter, histories, valids; the
// line store is not cleared (entries are written before the row below reads).
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction (None, Sub, Up, Average, Paeth).
// ----------------------------------------------------------------------------
module png_scanline_unfilter
    import psu_pkg::*;
#(
    parameter int LINE_BYTES      = 4096,
    parameter int MAX_PIXEL_BYTES = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    psu_stream_if.sink           in_item,
    psu_stream_if.source         out_item
);

    localparam int AW  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int CW  = (AW + 2 > LEN_W) ? AW + 2 : LEN_W;
    localparam int HW  = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
    localparam int PW  = BPP_W + 1;

    logic [BPP_W-1:0]  bpp_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [AW-1:0]     col_reg;
    logic [AW-1:0]     col_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    psu_stage_t        stage_reg;
    logic [AW-1:0]     s1_col_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    psu_out_item_t     out_data_reg;

    logic              accept;
    logic              s1_adv;
    logic [PW-1:0]     bpp_eff;
    logic [HW-1:0]     tap;
    logic [CW-1:0]     len_eff;
    logic [CW-1:0]     col_inc;
    logic              eol_now;
    logic              has_left_now;
    logic [BYTE_W-1:0] ram_q;
    logic [BYTE_W-1:0] above;
    logic [BYTE_W-1:0] left;
    logic [BYTE_W-1:0] upper_left;
    logic [BYTE_W-1:0] raw;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= BPP_RESET;
            len_reg <= LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BPP: bpp_reg <= cfg_data[BPP_W-1:0];
                CFG_LEN: len_reg <= cfg_data[LEN_W-1:0];
            endcase
        end
    end

    // Clamped pixel size and line length
    always_comb
    begin
        if (bpp_reg == '0)
        begin
            bpp_eff = PW'(1);
        end
        else if (PW'(bpp_reg) > PW'(MAX_PIXEL_BYTES))
        begin
            bpp_eff = PW'(MAX_PIXEL_BYTES);
        end
        else
        begin
            bpp_eff = PW'(bpp_reg);
        end
        tap = HW'(bpp_eff - PW'(1));

        if (len_reg == '0)
        begin
            len_eff = CW'(1);
        end
        else if (CW'(len_reg) > CW'(LINE_BYTES))
        begin
            len_eff = CW'(LINE_BYTES);
        end
        else
        begin
            len_eff = CW'(len_reg);
        end
    end

    assign accept        = in_item.valid && in_item.ready;
    assign s1_adv        = s1_valid_reg && (!out_valid_reg || out_item.ready);
    assign in_item.ready = !s1_valid_reg || s1_adv;

    assign col_inc      = CW'(col_reg) + CW'(1);
    assign eol_now      = (col_inc >= len_eff);
    assign has_left_now = (CW'(col_reg) >= CW'(bpp_eff));
    assign col_next     = eol_now ? '0 : col_inc[AW-1:0];

    assign s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
    assign out_valid_next = s1_adv ? 1'b1 : (out_item.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.filter_type   <= in_item.data.filter_type;
            stage_reg.filtered_byte <= in_item.data.filtered_byte;
            stage_reg.first_row     <= in_item.data.first_row;
            stage_reg.has_left      <= has_left_now;
            stage_reg.end_of_line   <= eol_now;
            s1_col_reg              <= col_reg;
        end
        if (s1_adv)
        begin
            out_data_reg.raw_byte    <= raw;
            out_data_reg.end_of_line <= stage_reg.end_of_line;
        end
    end

    psu_line_ram #(
        .DEPTH (LINE_BYTES)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (raw),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_q)
    );

    assign above = stage_reg.first_row ? '0 : ram_q;

    psu_history #(
        .DEPTH (MAX_PIXEL_BYTES)
    ) u_history (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift      (s1_adv),
        .raw_in     (raw),
        .above_in   (above),
        .tap        (tap),
        .has_left   (stage_reg.has_left),
        .first_row  (stage_reg.first_row),
        .left       (left),
        .upper_left (upper_left)
    );

    psu_predict u_predict (
        .stage      (stage_reg),
        .left       (left),
        .above      (above),
        .upper_left (upper_left),
        .raw        (raw)
    );

    assign out_item.valid = out_valid_reg;
    assign out_item.data  = out_data_reg;

`ifndef SYNTHESIS
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(col_reg) < CW'(LINE_BYTES))
        else $error("column beyond line store");

    a_eol_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && eol_now) |=> (col_reg == '0))
        else $error("column did not wrap after end of line");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(stage_reg)))
        else $error("stalled item lost from reconstruct stage");

    a_ready_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_item.ready |-> (s1_valid_reg && out_valid_reg && !out_item.ready))
        else $error("input held off while pipeline has room");

    a_first_row_up: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && stage_reg.first_row && (stage_reg.filter_type == FT_UP))
            |-> (raw == stage_reg.filtered_byte))
        else $error("up filter on first row must pass byte through");
`endif

endmodule
